/* hdl/mobm_pkg.sv */
// shared types and constants of the multicart outer bank mapper
`default_nettype none

package mobm_pkg;

   // command codes of one request
   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_PRG    = 2'd1,
      CMD_CHR    = 2'd2,
      CMD_MIRROR = 2'd3
   } cmd_type;

   // csr register indexes
   localparam logic [1:0] CSR_VARIANT    = 2'd0;
   localparam logic [1:0] CSR_CHR_RAM    = 2'd1;
   localparam logic [1:0] CSR_CHIP_SPLIT = 2'd2;

   localparam logic [3:0]  VARIANT_RESET = 4'd0;
   localparam logic [11:0] SPLIT_RESET   = 12'd2048;

   // board kinds (variant with bit zero dropped)
   localparam logic [2:0] KIND_WIDE  = 3'd1;  // variants 2 and 3
   localparam logic [2:0] KIND_NARROW = 3'd2; // variants 4 and 5
   localparam logic [2:0] KIND_SPLIT = 3'd3;  // variants 6 and 7
   localparam logic [2:0] KIND_CHRWP = 3'd4;  // variants 8 and 9
   localparam logic [2:0] KIND_SCREEN = 3'd5; // variants 10 and 11

   // outer register roles
   localparam int OREG_BASE = 0;
   localparam int OREG_EXT  = 1;
   localparam int OREG_CHR  = 2;
   localparam int OREG_CTRL = 3;
   localparam int OREG_RAM  = 4;

   // mirroring codes
   localparam logic [1:0] MIR_HORIZONTAL = 2'd0;
   localparam logic [1:0] MIR_SCREEN_A   = 2'd2;

   typedef struct packed {
      logic [3:0]  variant;
      logic        chr_ram_present;
      logic [11:0] chip_split;
   } cfg_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] addr;
      logic [7:0]  value;
      logic        inner_chr_invert;
      logic        inner_mirror;
   } req_type;

   typedef struct packed {
      logic        write_taken;
      logic [11:0] bank;
      logic        use_chr_ram;
      logic        chr_writable;
      logic [1:0]  mirroring;
   } rsp_type;

endpackage

`default_nettype wire

/* hdl/multicart_outer_bank_mapper_unit.sv */
// top level of the multicart outer bank mapper
// path: a request is held in the input register, then in the response register, whose valid flag drives rsp_valid
// throughput: one request per cycle while rsp_stall is low; the input register and the response register
// form a two-entry pipeline, so a new request is taken while a response waits
// reset: synchronous active high; clears all outer registers, valid flags and
// the csr registers (variant 0, no chr ram, chip split 2048)
`default_nettype none

module multicart_outer_bank_mapper_unit #(
   parameter int OUTER_REG_COUNT = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [15:0] req_addr,
   input  wire logic [7:0]  req_value,
   input  wire logic        req_inner_chr_invert,
   input  wire logic        req_inner_mirror,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_write_taken,
   output logic [11:0]      rsp_bank,
   output logic             rsp_use_chr_ram,
   output logic             rsp_chr_writable,
   output logic [1:0]       rsp_mirroring,
   // csr write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [11:0] csr_data
);

   localparam int IDX_W = $clog2(OUTER_REG_COUNT);

   // csr registers
   mobm_pkg::cfg_type cfg_ff;

   // input stage
   logic              in_valid_ff, in_valid_in;
   mobm_pkg::req_type in_item_ff;

   // response stage
   logic              out_valid_ff, out_valid_in;
   mobm_pkg::rsp_type out_item_ff, out_item_in;

   logic                            req_accept;
   logic                            advance;
   logic                            wr_en;
   logic                            wr_allowed;
   logic [OUTER_REG_COUNT-1:0][7:0] regs;
   mobm_pkg::rsp_type               xlate_rsp;

   // csr writes are always taken; an index past the list is dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.variant         <= mobm_pkg::VARIANT_RESET;
         cfg_ff.chr_ram_present <= 1'b0;
         cfg_ff.chip_split      <= mobm_pkg::SPLIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mobm_pkg::CSR_VARIANT: begin
               cfg_ff.variant <= csr_data[3:0];
            end
            mobm_pkg::CSR_CHR_RAM: begin
               cfg_ff.chr_ram_present <= csr_data[0];
            end
            mobm_pkg::CSR_CHIP_SPLIT: begin
               cfg_ff.chip_split <= csr_data;
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // the input stage moves on whenever the response register is free or drains
   assign advance    = !out_valid_ff || !rsp_stall;
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.cmd              <= mobm_pkg::cmd_type'(req_cmd);
         in_item_ff.addr             <= req_addr;
         in_item_ff.value            <= req_value;
         in_item_ff.inner_chr_invert <= req_inner_chr_invert;
         in_item_ff.inner_mirror     <= req_inner_mirror;
      end
      if (advance && in_valid_ff) begin
         out_item_ff <= out_item_in;
      end
   end

   // register writes commit as the item leaves the input stage, so later
   // queries in the pipe always see them in order
   assign wr_en = advance && in_valid_ff && (in_item_ff.cmd == mobm_pkg::CMD_WRITE);

   mobm_regfile #(
      .OUTER_REG_COUNT(OUTER_REG_COUNT)
   ) u_regfile (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_idx     (in_item_ff.addr[IDX_W-1:0]),
      .wr_data    (in_item_ff.value),
      .wr_allowed (wr_allowed),
      .regs       (regs)
   );

   mobm_xlate #(
      .OUTER_REG_COUNT(OUTER_REG_COUNT)
   ) u_xlate (
      .cfg    (cfg_ff),
      .regs   (regs),
      .item   (in_item_ff),
      .result (xlate_rsp)
   );

   // writes report only whether the entry was stored
   always_comb begin
      out_item_in = xlate_rsp;
      if (in_item_ff.cmd == mobm_pkg::CMD_WRITE) begin
         out_item_in             = '0;
         out_item_in.write_taken = wr_allowed;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_write_taken  = out_item_ff.write_taken;
   assign rsp_bank         = out_item_ff.bank;
   assign rsp_use_chr_ram  = out_item_ff.use_chr_ram;
   assign rsp_chr_writable = out_item_ff.chr_writable;
   assign rsp_mirroring    = out_item_ff.mirroring;

endmodule

`default_nettype wire

/* hdl/mobm_regfile.sv */
// outer register file with lock and partial field lock on write
`default_nettype none

module mobm_regfile #(
   parameter int OUTER_REG_COUNT = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              wr_en,
   input  wire logic [$clog2(OUTER_REG_COUNT)-1:0] wr_idx,
   input  wire logic [7:0]                        wr_data,
   output logic                                   wr_allowed,
   output logic [OUTER_REG_COUNT-1:0][7:0]        regs
);

   localparam int IDX_W = $clog2(OUTER_REG_COUNT);

   logic [OUTER_REG_COUNT-1:0][7:0] regs_ff;
   logic [7:0] reg2;
   logic [7:0] merged;
   logic [7:0] data_in;
   logic       is_chr_reg;

   assign reg2       = regs_ff[mobm_pkg::OREG_CHR];
   assign is_chr_reg = (wr_idx == IDX_W'(mobm_pkg::OREG_CHR));

   // lock bit blocks everything but the chr register
   assign wr_allowed = !regs_ff[mobm_pkg::OREG_CTRL][7] || is_chr_reg;

   always_comb begin
      merged = reg2[7] ? {reg2[7:4], wr_data[3:0]} : wr_data;
      if (is_chr_reg) begin
         data_in = merged & {4'hF, ~reg2[6:4], 1'b1};
      end else begin
         data_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else if (wr_en && wr_allowed) begin
         regs_ff[wr_idx] <= data_in;
      end
   end

   assign regs = regs_ff;

endmodule

`default_nettype wire

/* hdl/mobm_xlate.sv */
// prg, chr and mirroring translation from the outer registers
`default_nettype none

module mobm_xlate #(
   parameter int OUTER_REG_COUNT = 8
) (
   input  wire mobm_pkg::cfg_type                 cfg,
   input  wire logic [OUTER_REG_COUNT-1:0][7:0]   regs,
   input  wire mobm_pkg::req_type                 item,
   output mobm_pkg::rsp_type                      result
);

   logic [7:0]  r0, r1, r2, r3, r4;
   logic [2:0]  kind;
   logic [11:0] prg_base, prg_mask, prg_v, prg_bank;
   logic [12:0] split13, split_base;
   logic        split_high;
   logic [11:0] chr_base, chr_mask, chr_v, chr_bank;
   logic        chr_ram, chr_wr;
   logic [1:0]  mir;

   assign r0   = regs[mobm_pkg::OREG_BASE];
   assign r1   = regs[mobm_pkg::OREG_EXT];
   assign r2   = regs[mobm_pkg::OREG_CHR];
   assign r3   = regs[mobm_pkg::OREG_CTRL];
   assign r4   = regs[mobm_pkg::OREG_RAM];
   assign kind = cfg.variant[3:1];

   // prg bank
   assign split13    = (cfg.chip_split == 12'd0) ? 13'h1000 : {1'b0, cfg.chip_split};
   assign split_high = r0[7] ? r0[3] : item.inner_chr_invert;

   always_comb begin
      case (kind)
         mobm_pkg::KIND_WIDE: begin
            prg_base = {r0[5:4], r1[1], r1[2], r1[3], r0[2:0], r3[3:1], 1'b0};
         end
         mobm_pkg::KIND_NARROW: begin
            prg_base = {3'b000, r0[5:4], r0[2:0], r3[3:1], 1'b0};
         end
         default: begin
            prg_base = {r0[5:4], r1[3:2], r1[4], r0[2:0], r3[3:1], 1'b0};
         end
      endcase
      split_base = ({1'b0, prg_base} & (split13 - 13'd1)) | (split_high ? split13 : 13'd0);
      if (kind == mobm_pkg::KIND_SPLIT) begin
         prg_base = split_base[11:0];
      end
      // gnrom mode takes the low bank bits straight from the cpu address
      if (r3[4]) begin
         if (kind == mobm_pkg::KIND_WIDE) begin
            prg_mask = r1[4] ? 12'h001 : 12'h003;
         end else begin
            prg_mask = r1[1] ? 12'h003 : 12'h001;
         end
         prg_v = {9'd0, item.addr[15:13]};
      end else begin
         prg_mask = {4'h0, r1[5], r1[6], ~r1[7], ~r0[6], 4'hF};
         prg_v    = {4'h0, item.value};
      end
      prg_bank = (prg_base & ~prg_mask) | (prg_v & prg_mask);
   end

   // chr bank
   always_comb begin
      chr_base = {2'b00, r0[5:3], r2[3:0], 3'b000};
      chr_ram  = cfg.chr_ram_present && r4[0] && (item.value[7:1] == r4[7:1]);
      chr_wr   = chr_ram;
      if (!chr_ram && kind == mobm_pkg::KIND_CHRWP) begin
         chr_wr = r0[4];
      end
      if (r3[4]) begin
         chr_mask = 12'h007;
         chr_v    = {6'd0, item.addr[15:10]};
      end else begin
         chr_mask = r0[7] ? 12'h07F : 12'h0FF;
         chr_v    = {4'h0, item.value};
      end
      chr_bank = (chr_base & ~chr_mask) | (chr_v & chr_mask);
   end

   // mirroring
   always_comb begin
      if (!r0[5] && kind == mobm_pkg::KIND_SCREEN) begin
         mir = mobm_pkg::MIR_SCREEN_A | {1'b0, r0[4]};
      end else begin
         mir = mobm_pkg::MIR_HORIZONTAL | {1'b0, ~item.inner_mirror};
      end
   end

   always_comb begin
      result = '0;
      case (item.cmd)
         mobm_pkg::CMD_PRG: begin
            result.bank = prg_bank;
         end
         mobm_pkg::CMD_CHR: begin
            result.bank         = chr_bank;
            result.use_chr_ram  = chr_ram;
            result.chr_writable = chr_wr;
         end
         mobm_pkg::CMD_MIRROR: begin
            result.mirroring = mir;
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

`default_nettype wire
